// ----- rtl/core/sird_pkg.sv -----
// shared types, constants and command structs for the sir grid step block
// no dependencies; compile first
package sird_pkg;

    localparam int GRID_SIZE = 64;
    localparam int CELLS     = GRID_SIZE * GRID_SIZE;
    localparam int ADDR_W    = $clog2(CELLS);
    localparam int RC_W      = $clog2(GRID_SIZE);

    localparam int ACTION_W  = 2;
    localparam int STATUS_W  = 2;
    localparam int POS_W     = 6;
    localparam int DATA_W    = 32;
    localparam int GAIN_W    = 28;
    localparam int CFG_IDX_W = 3;
    localparam int FRAC_W    = 24;

    // datapath widths
    localparam int LAP_W     = 35;
    localparam int MUL_A_W   = 33;
    localparam int PROD_W    = MUL_A_W + LAP_W;
    localparam int TERM_W    = 40;
    localparam int SUM_W     = 43;

    typedef enum logic [ACTION_W-1:0] {
        ACT_WRITE = 2'd0,
        ACT_READ  = 2'd1,
        ACT_STEP  = 2'd2,
        ACT_NONE  = 2'd3
    } action_t;

    localparam logic [STATUS_W-1:0] STAT_WRITE = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_READ  = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_STEP  = 2'd2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_S_DIFF   = 3'd0,
        CFG_SI_CROSS = 3'd1,
        CFG_I_DIFF   = 3'd2,
        CFG_R_DIFF   = 3'd3,
        CFG_INFECT   = 3'd4,
        CFG_RECOVER  = 3'd5,
        CFG_DECAY    = 3'd6
    } cfg_idx_t;

    localparam logic [GAIN_W-1:0] RST_S_DIFF   = 28'd167772;
    localparam logic [GAIN_W-1:0] RST_SI_CROSS = 28'd838861;
    localparam logic [GAIN_W-1:0] RST_I_DIFF   = 28'd167772;
    localparam logic [GAIN_W-1:0] RST_R_DIFF   = 28'd16777216;
    localparam logic [GAIN_W-1:0] RST_INFECT   = 28'd1677722;
    localparam logic [GAIN_W-1:0] RST_RECOVER  = 28'd67109;
    localparam logic [GAIN_W-1:0] RST_DECAY    = 28'd1677722;

    // stencil taps, in read order
    typedef enum logic [2:0] {
        NB_C = 3'd0,
        NB_U = 3'd1,
        NB_D = 3'd2,
        NB_L = 3'd3,
        NB_R = 3'd4
    } nb_t;

    // shared multiplier jobs, in issue order
    typedef enum logic [2:0] {
        MUL_SI  = 3'd0,
        MUL_REC = 3'd1,
        MUL_DEC = 3'd2,
        MUL_LS  = 3'd3,
        MUL_LIS = 3'd4,
        MUL_LII = 3'd5,
        MUL_LR  = 3'd6,
        MUL_INF = 3'd7
    } mul_t;

    typedef struct packed {
        logic                latch;
        logic                host_wr;
        logic                res_load;
        logic                step_rd;
        nb_t                 rd_nb;
        logic                cap_en;
        nb_t                 cap_nb;
        logic                mul_en;
        mul_t                mul_op;
        logic                upd_wr;
        logic                cell_clr;
        logic                cell_next;
        logic                out_load;
        logic [STATUS_W-1:0] out_status;
    } dp_cmd_t;

    typedef struct packed {
        logic last_cell;
    } dp_stat_t;

endpackage

// ----- rtl/core/sird_in_if.sv -----
// request channel: action, cell address and cell values
// depends on sird_pkg
interface sird_in_if;
    import sird_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [ACTION_W-1:0]      action;
    logic [POS_W-1:0]         row;
    logic [POS_W-1:0]         col;
    logic signed [DATA_W-1:0] s_in;
    logic signed [DATA_W-1:0] i_in;
    logic signed [DATA_W-1:0] r_in;

    modport source (output valid, action, row, col, s_in, i_in, r_in, input ready);
    modport sink   (input valid, action, row, col, s_in, i_in, r_in, output ready);
endinterface

// ----- rtl/core/sird_out_if.sv -----
// result channel: status and cell values
// depends on sird_pkg
interface sird_out_if;
    import sird_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [STATUS_W-1:0]      status;
    logic signed [DATA_W-1:0] s_out;
    logic signed [DATA_W-1:0] i_out;
    logic signed [DATA_W-1:0] r_out;

    modport source (output valid, status, s_out, i_out, r_out, input ready);
    modport sink   (input valid, status, s_out, i_out, r_out, output ready);
endinterface

// ----- rtl/core/sird_ram.sv -----
// generic simple dual port ram, one write and one registered read per cycle
// no dependencies
module sird_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

// ----- rtl/core/sird_dp.sv -----
// datapath: grids, gain registers, stencil accumulation, shared multiplier
// depends on sird_pkg and sird_ram
module sird_dp (
    input  logic                               clk,
    input  logic                               rst_n,
    input  sird_pkg::dp_cmd_t                  cmd,
    output sird_pkg::dp_stat_t                 stat,
    input  logic                               cfg_we,
    input  logic [sird_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [sird_pkg::GAIN_W-1:0]        cfg_data,
    input  logic [sird_pkg::POS_W-1:0]         in_row,
    input  logic [sird_pkg::POS_W-1:0]         in_col,
    input  logic signed [sird_pkg::DATA_W-1:0] in_s,
    input  logic signed [sird_pkg::DATA_W-1:0] in_i,
    input  logic signed [sird_pkg::DATA_W-1:0] in_r,
    output logic [sird_pkg::STATUS_W-1:0]      out_status,
    output logic signed [sird_pkg::DATA_W-1:0] out_s,
    output logic signed [sird_pkg::DATA_W-1:0] out_i,
    output logic signed [sird_pkg::DATA_W-1:0] out_r
);
    import sird_pkg::*;

    localparam logic signed [PROD_W-1:0] DMAX =
        {{(PROD_W-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}};
    localparam logic signed [PROD_W-1:0] DMIN =
        {{(PROD_W-DATA_W+1){1'b1}}, {(DATA_W-1){1'b0}}};
    localparam logic [RC_W-1:0]   RC_LAST = RC_W'(GRID_SIZE - 1);
    localparam logic [ADDR_W-1:0] ROW_STEP = ADDR_W'(GRID_SIZE);

    function automatic logic signed [DATA_W-1:0] sat_data(input logic signed [PROD_W-1:0] v);
        if (v > DMAX)
            sat_data = DMAX[DATA_W-1:0];
        else if (v < DMIN)
            sat_data = DMIN[DATA_W-1:0];
        else
            sat_data = v[DATA_W-1:0];
    endfunction

    // gains
    logic [GAIN_W-1:0] g_s_diff_reg, g_si_cross_reg, g_i_diff_reg, g_r_diff_reg;
    logic [GAIN_W-1:0] g_infect_reg, g_recover_reg, g_decay_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            g_s_diff_reg   <= RST_S_DIFF;
            g_si_cross_reg <= RST_SI_CROSS;
            g_i_diff_reg   <= RST_I_DIFF;
            g_r_diff_reg   <= RST_R_DIFF;
            g_infect_reg   <= RST_INFECT;
            g_recover_reg  <= RST_RECOVER;
            g_decay_reg    <= RST_DECAY;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_S_DIFF:   g_s_diff_reg   <= cfg_data;
                CFG_SI_CROSS: g_si_cross_reg <= cfg_data;
                CFG_I_DIFF:   g_i_diff_reg   <= cfg_data;
                CFG_R_DIFF:   g_r_diff_reg   <= cfg_data;
                CFG_INFECT:   g_infect_reg   <= cfg_data;
                CFG_RECOVER:  g_recover_reg  <= cfg_data;
                CFG_DECAY:    g_decay_reg    <= cfg_data;
                default:      ;
            endcase
        end
    end

    // latched host request
    logic [POS_W-1:0]         row_reg, col_reg;
    logic signed [DATA_W-1:0] hs_reg, hi_reg, hr_reg;
    logic                     host_in_grid;
    logic [ADDR_W-1:0]        k_host;

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            row_reg <= in_row;
            col_reg <= in_col;
            hs_reg  <= in_s;
            hi_reg  <= in_i;
            hr_reg  <= in_r;
        end
    end

    assign host_in_grid = (32'(row_reg) < GRID_SIZE) && (32'(col_reg) < GRID_SIZE);
    assign k_host = ADDR_W'(ADDR_W'(row_reg) * ROW_STEP) + ADDR_W'(col_reg);

    // sweep counters
    logic [RC_W-1:0]   r_reg, c_reg;
    logic [ADDR_W-1:0] k_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.cell_clr)
        begin
            r_reg <= '0;
            c_reg <= '0;
            k_reg <= '0;
        end
        else if (cmd.cell_next)
        begin
            k_reg <= k_reg + 1'b1;
            if (c_reg == RC_LAST)
            begin
                c_reg <= '0;
                r_reg <= r_reg + 1'b1;
            end
            else
            begin
                c_reg <= c_reg + 1'b1;
            end
        end
    end

    assign stat.last_cell = (r_reg == RC_LAST) && (c_reg == RC_LAST);

    // memories
    logic [ADDR_W-1:0]        raddr, waddr;
    logic                     we;
    logic signed [DATA_W-1:0] s_rd, i_rd, r_rd;
    logic signed [DATA_W-1:0] s_new, i_new, r_new;
    logic signed [DATA_W-1:0] s_wd, i_wd, r_wd;

    always_comb
    begin
        raddr = k_host;
        if (cmd.step_rd)
        begin
            case (cmd.rd_nb)
                NB_U:    raddr = k_reg - ROW_STEP;
                NB_D:    raddr = k_reg + ROW_STEP;
                NB_L:    raddr = k_reg - 1'b1;
                NB_R:    raddr = k_reg + 1'b1;
                default: raddr = k_reg;
            endcase
        end
    end

    assign we    = cmd.upd_wr || (cmd.host_wr && host_in_grid);
    assign waddr = cmd.upd_wr ? k_reg : k_host;
    assign s_wd  = cmd.upd_wr ? s_new : hs_reg;
    assign i_wd  = cmd.upd_wr ? i_new : hi_reg;
    assign r_wd  = cmd.upd_wr ? r_new : hr_reg;

    sird_ram #(.WIDTH(DATA_W), .DEPTH(CELLS)) u_s_ram (
        .clk(clk), .we(we), .waddr(waddr), .wdata(s_wd), .raddr(raddr), .rdata(s_rd)
    );
    sird_ram #(.WIDTH(DATA_W), .DEPTH(CELLS)) u_i_ram (
        .clk(clk), .we(we), .waddr(waddr), .wdata(i_wd), .raddr(raddr), .rdata(i_rd)
    );
    sird_ram #(.WIDTH(DATA_W), .DEPTH(CELLS)) u_r_ram (
        .clk(clk), .we(we), .waddr(waddr), .wdata(r_wd), .raddr(raddr), .rdata(r_rd)
    );

    // stencil capture; missing edge neighbours contribute nothing
    logic signed [DATA_W-1:0] sc_reg, ic_reg, rc_reg;
    logic signed [LAP_W-1:0]  lap_s_reg, lap_i_reg, lap_r_reg;
    logic                     nb_use;

    always_comb
    begin
        case (cmd.cap_nb)
            NB_U:    nb_use = (r_reg != '0);
            NB_D:    nb_use = (r_reg != RC_LAST);
            NB_L:    nb_use = (c_reg != '0);
            NB_R:    nb_use = (c_reg != RC_LAST);
            default: nb_use = 1'b0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.cap_en)
        begin
            if (cmd.cap_nb == NB_C)
            begin
                sc_reg    <= s_rd;
                ic_reg    <= i_rd;
                rc_reg    <= r_rd;
                lap_s_reg <= '0;
                lap_i_reg <= '0;
                lap_r_reg <= '0;
            end
            else if (nb_use)
            begin
                lap_s_reg <= lap_s_reg + LAP_W'(s_rd) - LAP_W'(sc_reg);
                lap_i_reg <= lap_i_reg + LAP_W'(i_rd) - LAP_W'(ic_reg);
                lap_r_reg <= lap_r_reg + LAP_W'(r_rd) - LAP_W'(rc_reg);
            end
        end
    end

    // shared multiplier, product registered, then scaled into a term
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [LAP_W-1:0]   mul_b;
    logic signed [PROD_W-1:0]  prod_reg, prod_sh;
    mul_t                      prod_op_reg;
    logic                      prod_v_reg;
    logic signed [DATA_W-1:0]  si_reg;
    logic signed [TERM_W-1:0]  rec_reg, dec_reg, ls_reg, lis_reg, lii_reg, lr_reg, inf_reg;
    logic signed [TERM_W-1:0]  term;

    always_comb
    begin
        case (cmd.mul_op)
            MUL_SI:
            begin
                mul_a = MUL_A_W'(sc_reg);
                mul_b = LAP_W'(ic_reg);
            end
            MUL_REC:
            begin
                mul_a = MUL_A_W'($signed({1'b0, g_recover_reg}));
                mul_b = LAP_W'(ic_reg);
            end
            MUL_DEC:
            begin
                mul_a = MUL_A_W'($signed({1'b0, g_decay_reg}));
                mul_b = LAP_W'(rc_reg);
            end
            MUL_LS:
            begin
                mul_a = MUL_A_W'($signed({1'b0, g_s_diff_reg}));
                mul_b = lap_s_reg;
            end
            MUL_LIS:
            begin
                mul_a = MUL_A_W'($signed({1'b0, g_si_cross_reg}));
                mul_b = lap_i_reg;
            end
            MUL_LII:
            begin
                mul_a = MUL_A_W'($signed({1'b0, g_i_diff_reg}));
                mul_b = lap_i_reg;
            end
            MUL_LR:
            begin
                mul_a = MUL_A_W'($signed({1'b0, g_r_diff_reg}));
                mul_b = lap_r_reg;
            end
            default:
            begin
                mul_a = MUL_A_W'($signed({1'b0, g_infect_reg}));
                mul_b = LAP_W'(si_reg);
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_v_reg <= 1'b0;
        end
        else
        begin
            prod_v_reg <= cmd.mul_en;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul_en)
        begin
            prod_reg    <= PROD_W'(mul_a) * PROD_W'(mul_b);
            prod_op_reg <= cmd.mul_op;
        end
    end

    // floor division by 2^24
    assign prod_sh = prod_reg >>> FRAC_W;
    assign term    = prod_sh[TERM_W-1:0];

    always_ff @(posedge clk)
    begin
        if (prod_v_reg)
        begin
            case (prod_op_reg)
                MUL_SI:  si_reg  <= sat_data(prod_sh);
                MUL_REC: rec_reg <= term;
                MUL_DEC: dec_reg <= term;
                MUL_LS:  ls_reg  <= term;
                MUL_LIS: lis_reg <= term;
                MUL_LII: lii_reg <= term;
                MUL_LR:  lr_reg  <= term;
                default: inf_reg <= term;
            endcase
        end
    end

    // cell update
    logic signed [SUM_W-1:0] s_sum, i_sum, r_sum;

    assign s_sum = SUM_W'(sc_reg) - SUM_W'(inf_reg) + SUM_W'(ls_reg) + SUM_W'(lis_reg);
    assign i_sum = SUM_W'(ic_reg) + SUM_W'(inf_reg) - SUM_W'(rec_reg) + SUM_W'(lii_reg);
    assign r_sum = SUM_W'(rc_reg) + SUM_W'(rec_reg) - SUM_W'(dec_reg) + SUM_W'(lr_reg);
    assign s_new = sat_data(PROD_W'(s_sum));
    assign i_new = sat_data(PROD_W'(i_sum));
    assign r_new = sat_data(PROD_W'(r_sum));

    // result staging and output register
    logic signed [DATA_W-1:0] res_s_reg, res_i_reg, res_r_reg;
    logic [STATUS_W-1:0]      out_status_reg;
    logic signed [DATA_W-1:0] out_s_reg, out_i_reg, out_r_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            res_s_reg <= '0;
            res_i_reg <= '0;
            res_r_reg <= '0;
        end
        else if (cmd.res_load && host_in_grid)
        begin
            res_s_reg <= s_rd;
            res_i_reg <= i_rd;
            res_r_reg <= r_rd;
        end
        if (cmd.out_load)
        begin
            out_status_reg <= cmd.out_status;
            out_s_reg      <= res_s_reg;
            out_i_reg      <= res_i_reg;
            out_r_reg      <= res_r_reg;
        end
    end

    assign out_status = out_status_reg;
    assign out_s      = out_s_reg;
    assign out_i      = out_i_reg;
    assign out_r      = out_r_reg;
endmodule

// ----- rtl/core/sird_ctrl.sv -----
// controller: request sequencing and per-cell phase schedule
// depends on sird_pkg
module sird_ctrl (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [sird_pkg::ACTION_W-1:0]   in_action,
    output logic                            out_valid,
    input  logic                            out_ready,
    output sird_pkg::dp_cmd_t               cmd,
    input  sird_pkg::dp_stat_t              stat
);
    import sird_pkg::*;

    localparam logic [3:0] PH_RD_LAST  = 4'd4;
    localparam logic [3:0] PH_CAP_LAST = 4'd5;
    localparam logic [3:0] PH_MUL_0    = 4'd6;
    localparam logic [3:0] PH_MUL_LAST = 4'd13;
    localparam logic [3:0] PH_UPD      = 4'd15;

    typedef enum logic [2:0] {
        S_IDLE, S_WR, S_RD, S_RDCAP, S_STEP, S_RESP
    } state_t;

    state_t              state_reg, state_next;
    logic [3:0]          ph_reg, ph_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic                out_valid_reg, out_valid_next;
    logic                accept;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign accept    = in_valid && in_ready;

    always_comb
    begin
        cmd            = '0;
        cmd.out_status = status_reg;
        state_next     = state_reg;
        ph_next        = ph_reg;
        status_next    = status_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.latch = accept;
                if (accept)
                begin
                    unique case (action_t'(in_action))
                        ACT_WRITE:
                        begin
                            state_next  = S_WR;
                            status_next = STAT_WRITE;
                        end
                        ACT_READ:
                        begin
                            state_next  = S_RD;
                            status_next = STAT_READ;
                        end
                        ACT_STEP:
                        begin
                            state_next   = S_STEP;
                            status_next  = STAT_STEP;
                            ph_next      = '0;
                            cmd.cell_clr = 1'b1;
                        end
                        ACT_NONE:
                        begin
                            state_next  = S_RESP;
                            status_next = STAT_WRITE;
                        end
                    endcase
                end
            end
            S_WR:
            begin
                cmd.host_wr = 1'b1;
                state_next  = S_RESP;
            end
            S_RD:
            begin
                state_next = S_RDCAP;
            end
            S_RDCAP:
            begin
                cmd.res_load = 1'b1;
                state_next   = S_RESP;
            end
            S_STEP:
            begin
                // five reads, each captured in the cycle after it
                if (ph_reg <= PH_RD_LAST)
                begin
                    cmd.step_rd = 1'b1;
                    cmd.rd_nb   = nb_t'(ph_reg[2:0]);
                end
                if (ph_reg != '0 && ph_reg <= PH_CAP_LAST)
                begin
                    cmd.cap_en = 1'b1;
                    cmd.cap_nb = nb_t'(3'(ph_reg - 4'd1));
                end
                // eight products through the shared multiplier
                if (ph_reg >= PH_MUL_0 && ph_reg <= PH_MUL_LAST)
                begin
                    cmd.mul_en = 1'b1;
                    cmd.mul_op = mul_t'(3'(ph_reg - PH_MUL_0));
                end
                ph_next = ph_reg + 1'b1;
                if (ph_reg == PH_UPD)
                begin
                    cmd.upd_wr    = 1'b1;
                    cmd.cell_next = 1'b1;
                    if (stat.last_cell)
                    begin
                        state_next = S_RESP;
                    end
                end
            end
            S_RESP:
            begin
                cmd.out_load = !out_valid_reg || out_ready;
                if (cmd.out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        out_valid_next = out_valid_reg;
        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ph_reg        <= '0;
            status_reg    <= STAT_WRITE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ph_reg        <= ph_next;
            status_reg    <= status_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !in_ready)
        else $error("request taken while a request is in flight");

    a_last_cell_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_STEP && ph_reg == PH_UPD && stat.last_cell) |=> state_reg == S_RESP)
        else $error("sweep did not end after the last cell");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == S_RESP)
        else $error("result raised outside the response state");

    a_read_latency: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_RD |=> state_reg == S_RDCAP)
        else $error("read data not captured after ram latency");
endmodule

// ----- rtl/core/sir_reaction_diffusion_grid_step.sv -----
// top level of the sir reaction-diffusion grid step block
// depends on sird_pkg, sird_in_if, sird_out_if, sird_ctrl, sird_dp
//
// channel   dir  handshake     payload
// item      in   valid/ready   action, row, col, s_in, i_in, r_in
// result    out  valid/ready   status, s_out, i_out, r_out
// cfg       in   cfg_we        cfg_index, cfg_data (28 bit gain)
//
// write request: passes through S_WR and S_RESP; read request: S_RD, S_RDCAP and S_RESP
// step request: sweeps every cell in row-major order, each cell's schedule set by
//   five stencil reads through the single read port of each grid ram and eight
//   products through one shared multiplier
// one request at a time; a finished result waits in the output register
// while the next request is accepted
// reset clears control and restores gains; grid contents are undefined until written
module sir_reaction_diffusion_grid_step (
    input  logic                            clk,
    input  logic                            rst_n,
    sird_in_if.sink                         item,
    sird_out_if.source                      result,
    input  logic                            cfg_we,
    input  logic [sird_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [sird_pkg::GAIN_W-1:0]     cfg_data
);
    import sird_pkg::*;

    // command and status between controller and datapath
    dp_cmd_t  cmd;
    dp_stat_t stat;

    // controller owns both handshakes and the phase schedule
    sird_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (item.valid),
        .in_ready  (item.ready),
        .in_action (item.action),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .cmd       (cmd),
        .stat      (stat)
    );

    // datapath holds the grids, gains and the result register
    sird_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_row     (item.row),
        .in_col     (item.col),
        .in_s       (item.s_in),
        .in_i       (item.i_in),
        .in_r       (item.r_in),
        .out_status (result.status),
        .out_s      (result.s_out),
        .out_i      (result.i_out),
        .out_r      (result.r_out)
    );
endmodule

// ----- tb/sv/tb_sir_reaction_diffusion_grid_step.sv -----
// self-checking testbench for the sir reaction-diffusion grid step block
// depends on sird_pkg, sird_in_if, sird_out_if and the block itself
// predicts every result in place and checks it against the result channel
module tb_sir_reaction_diffusion_grid_step;
    import sird_pkg::*;

    localparam int WATCHDOG_LIMIT = 300000;
    localparam int HOLD_CYCLES    = 300;
    localparam int HOLD_AT_RESULT = 4110;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;
    localparam logic [GAIN_W-1:0]    GAIN_MAX   = 28'hFFFFFFF;

    typedef struct {
        action_t                  act;
        logic [POS_W-1:0]         row;
        logic [POS_W-1:0]         col;
        logic signed [DATA_W-1:0] s;
        logic signed [DATA_W-1:0] i;
        logic signed [DATA_W-1:0] r;
    } cell_req_t;

    typedef struct {
        logic [STATUS_W-1:0]      status;
        logic signed [DATA_W-1:0] s;
        logic signed [DATA_W-1:0] i;
        logic signed [DATA_W-1:0] r;
    } cell_resp_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [GAIN_W-1:0]    cfg_data = '0;

    sird_in_if  item ();
    sird_out_if result ();

    sir_reaction_diffusion_grid_step u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // predictor state: grids and gains as the block should hold them
    logic signed [DATA_W-1:0] s_grid_m [CELLS];
    logic signed [DATA_W-1:0] i_grid_m [CELLS];
    logic signed [DATA_W-1:0] r_grid_m [CELLS];
    logic [GAIN_W-1:0] g_sdiff, g_sicross, g_idiff, g_rdiff, g_infect, g_recover, g_decay;

    cell_req_t  pending_q[$];
    cell_resp_t expected_q[$];
    cell_req_t  drv_req;

    int tx_idle_pct = 0;
    int rx_stall_pct = 0;
    int mismatches = 0;
    int results_seen = 0;
    int rx_hold_left = 0;
    int idle_cycles = 0;

    // floor division by 2^24: arithmetic shift of a signed product
    function automatic longint floor_q(input longint p);
        return p >>> FRAC_W;
    endfunction

    function automatic longint mulq(input logic [GAIN_W-1:0] g, input longint v);
        longint gl;
        gl = longint'({36'd0, g});
        return floor_q(gl * v);
    endfunction

    function automatic logic signed [DATA_W-1:0] sat32(input longint v);
        if (v > 64'sd2147483647)
            return 32'sh7FFFFFFF;
        if (v < -64'sd2147483648)
            return 32'sh80000000;
        return v[DATA_W-1:0];
    endfunction

    // value of grid g (0 s, 1 i, 2 r) at row r, column c
    function automatic longint cell_val(input int g, input int r, input int c);
        int k;
        k = r * GRID_SIZE + c;
        case (g)
            0: return longint'(s_grid_m[k]);
            1: return longint'(i_grid_m[k]);
            default: return longint'(r_grid_m[k]);
        endcase
    endfunction

    // five-point laplacian, one-sided at the edges (zero flux)
    function automatic longint lap_at(input int g, input int r, input int c);
        longint v, dx, dy;
        v = cell_val(g, r, c);
        if (r == 0)
            dx = -v + cell_val(g, r + 1, c);
        else if (r == GRID_SIZE - 1)
            dx = -v + cell_val(g, r - 1, c);
        else
            dx = -2 * v + cell_val(g, r - 1, c) + cell_val(g, r + 1, c);
        if (c == 0)
            dy = -v + cell_val(g, r, c + 1);
        else if (c == GRID_SIZE - 1)
            dy = -v + cell_val(g, r, c - 1);
        else
            dy = -2 * v + cell_val(g, r, c - 1) + cell_val(g, r, c + 1);
        return dx + dy;
    endfunction

    // one euler step, in place and row-major like the block
    function automatic void euler_sweep();
        longint sv, iv, rv, ls, li, lr, si, inf, rec, dec;
        int k;
        for (int r = 0; r < GRID_SIZE; r++) begin
            for (int c = 0; c < GRID_SIZE; c++) begin
                k   = r * GRID_SIZE + c;
                sv  = s_grid_m[k];
                iv  = i_grid_m[k];
                rv  = r_grid_m[k];
                ls  = lap_at(0, r, c);
                li  = lap_at(1, r, c);
                lr  = lap_at(2, r, c);
                si  = longint'(sat32(floor_q(sv * iv)));
                inf = mulq(g_infect, si);
                rec = mulq(g_recover, iv);
                dec = mulq(g_decay, rv);
                s_grid_m[k] = sat32(sv - inf + mulq(g_sdiff, ls) + mulq(g_sicross, li));
                i_grid_m[k] = sat32(iv + inf - rec + mulq(g_idiff, li));
                r_grid_m[k] = sat32(rv + rec - dec + mulq(g_rdiff, lr));
            end
        end
    endfunction

    // apply one request to the predictor and return its result
    function automatic cell_resp_t predict_cell_req(input cell_req_t q);
        cell_resp_t e;
        int k;
        k = int'(q.row) * GRID_SIZE + int'(q.col);
        e = '{STAT_WRITE, 32'sd0, 32'sd0, 32'sd0};
        case (q.act)
            ACT_WRITE:
            begin
                s_grid_m[k] = q.s;
                i_grid_m[k] = q.i;
                r_grid_m[k] = q.r;
            end
            ACT_READ:
            begin
                e.status = STAT_READ;
                e.s = s_grid_m[k];
                e.i = i_grid_m[k];
                e.r = r_grid_m[k];
            end
            ACT_STEP:
            begin
                euler_sweep();
                e.status = STAT_STEP;
            end
            default:
            begin
            end
        endcase
        return e;
    endfunction

    // driver: one request offered at a time, random gaps between them
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item.valid  <= 1'b0;
            item.action <= ACT_WRITE;
            item.row    <= '0;
            item.col    <= '0;
            item.s_in   <= '0;
            item.i_in   <= '0;
            item.r_in   <= '0;
        end
        else if (item.valid && !item.ready)
        begin
            // request still waiting, hold it
        end
        else if (pending_q.size() > 0 && $urandom_range(99) >= tx_idle_pct)
        begin
            drv_req = pending_q.pop_front();
            expected_q.push_back(predict_cell_req(drv_req));
            item.valid  <= 1'b1;
            item.action <= drv_req.act;
            item.row    <= drv_req.row;
            item.col    <= drv_req.col;
            item.s_in   <= drv_req.s;
            item.i_in   <= drv_req.i;
            item.r_in   <= drv_req.r;
        end
        else
        begin
            item.valid <= 1'b0;
        end
    end

    // monitor: random stalls, one long hold-off, field compare against the oldest entry
    always @(posedge clk or negedge rst_n)
    begin : result_check
        cell_resp_t e;
        if (!rst_n)
        begin
            result.ready <= 1'b0;
        end
        else
        begin
            if (result.valid && result.ready)
            begin
                results_seen++;
                if (results_seen == HOLD_AT_RESULT)
                    rx_hold_left = HOLD_CYCLES;
                if (expected_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: status %0d s %0d i %0d r %0d",
                                 result.status, result.s_out, result.i_out, result.r_out);
                end
                else
                begin
                    e = expected_q.pop_front();
                    if (result.status !== e.status || result.s_out !== e.s
                        || result.i_out !== e.i || result.r_out !== e.r)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("result %0d: expected %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                                     results_seen, e.status, e.s, e.i, e.r, result.status,
                                     result.s_out, result.i_out, result.r_out);
                    end
                end
            end
            if (rx_hold_left > 0)
            begin
                rx_hold_left--;
                result.ready <= 1'b0;
            end
            else
                result.ready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // watchdog on cycles with no handshake on either channel
    always @(posedge clk)
    begin
        if ((item.valid && item.ready) || (result.valid && result.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic write_gain(input logic [CFG_IDX_W-1:0] idx, input logic [GAIN_W-1:0] v);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        case (idx)
            CFG_S_DIFF:   g_sdiff   = v;
            CFG_SI_CROSS: g_sicross = v;
            CFG_I_DIFF:   g_idiff   = v;
            CFG_R_DIFF:   g_rdiff   = v;
            CFG_INFECT:   g_infect  = v;
            CFG_RECOVER:  g_recover = v;
            CFG_DECAY:    g_decay   = v;
            default:      ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic write_all_gains(input logic [GAIN_W-1:0] v [7]);
        write_gain(CFG_S_DIFF,   v[0]);
        write_gain(CFG_SI_CROSS, v[1]);
        write_gain(CFG_I_DIFF,   v[2]);
        write_gain(CFG_R_DIFF,   v[3]);
        write_gain(CFG_INFECT,   v[4]);
        write_gain(CFG_RECOVER,  v[5]);
        write_gain(CFG_DECAY,    v[6]);
    endtask

    // sender pauses until the block is fully drained
    task automatic drain();
        while (pending_q.size() > 0 || item.valid || expected_q.size() > 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic queue_req(input action_t a, input int row, input int col,
                             input logic [31:0] s, input logic [31:0] i, input logic [31:0] r);
        cell_req_t q;
        q.act = a;
        q.row = row[POS_W-1:0];
        q.col = col[POS_W-1:0];
        q.s   = s;
        q.i   = i;
        q.r   = r;
        pending_q.push_back(q);
    endtask

    // random mix of writes and reads with a rare unused code; one step mid-way
    task automatic queue_random(input int n);
        int pick;
        for (int k = 0; k < n; k++)
        begin
            pick = $urandom_range(99);
            if (k == n / 2)
                queue_req(ACT_STEP, $urandom_range(63), $urandom_range(63),
                          $urandom, $urandom, $urandom);
            else if (pick < 45)
                queue_req(ACT_WRITE, $urandom_range(63), $urandom_range(63),
                          $urandom, $urandom, $urandom);
            else if (pick < 93)
                queue_req(ACT_READ, $urandom_range(63), $urandom_range(63),
                          $urandom, $urandom, $urandom);
            else
                queue_req(ACT_NONE, $urandom_range(63), $urandom_range(63),
                          $urandom, $urandom, $urandom);
        end
    endtask

    initial
    begin : stimulus
        logic [GAIN_W-1:0] gains [7];
        logic [31:0] pos_max, neg_max;
        pos_max = 32'h7FFFFFFF;
        neg_max = 32'h80000000;
        g_sdiff   = RST_S_DIFF;
        g_sicross = RST_SI_CROSS;
        g_idiff   = RST_I_DIFF;
        g_rdiff   = RST_R_DIFF;
        g_infect  = RST_INFECT;
        g_recover = RST_RECOVER;
        g_decay   = RST_DECAY;
        for (int k = 0; k < CELLS; k++)
        begin
            s_grid_m[k] = '0;
            i_grid_m[k] = '0;
            r_grid_m[k] = '0;
        end
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // phase 1, no idling: fill every cell so a step never sees unwritten data
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        for (int k = 0; k < CELLS; k++)
            queue_req(ACT_WRITE, k / GRID_SIZE, k % GRID_SIZE,
                      $urandom, $urandom, $urandom);
        // directed: extremes at the corners, the unused code and a step at reset gains
        queue_req(ACT_WRITE, 0, 0, pos_max, pos_max, pos_max);
        queue_req(ACT_WRITE, 63, 63, neg_max, neg_max, neg_max);
        queue_req(ACT_WRITE, 0, 63, 32'd0, 32'hFFFFFFFF, 32'd1);
        queue_req(ACT_WRITE, 63, 0, neg_max, pos_max, 32'd0);
        queue_req(ACT_READ, 0, 0, 0, 0, 0);
        queue_req(ACT_READ, 63, 63, 0, 0, 0);
        queue_req(ACT_READ, 0, 63, 0, 0, 0);
        queue_req(ACT_READ, 63, 0, 0, 0, 0);
        queue_req(ACT_NONE, 63, 63, pos_max, pos_max, pos_max);
        queue_req(ACT_READ, 63, 63, 0, 0, 0);
        queue_req(ACT_STEP, 0, 0, 0, 0, 0);
        queue_req(ACT_READ, 0, 0, 0, 0, 0);
        queue_req(ACT_READ, 63, 63, 0, 0, 0);
        queue_req(ACT_READ, 31, 32, 0, 0, 0);
        queue_random(35);
        drain();

        // phase 2, sender idle most of the time, all gains zero
        for (int g = 0; g < 7; g++)
            gains[g] = '0;
        write_all_gains(gains);
        tx_idle_pct = 76;
        queue_random(35);
        drain();

        // phase 3, receiver stalling, all gains at maximum plus an ignored index
        for (int g = 0; g < 7; g++)
            gains[g] = GAIN_MAX;
        write_all_gains(gains);
        write_gain(CFG_UNUSED, GAIN_W'($urandom));
        tx_idle_pct  = 0;
        rx_stall_pct = 76;
        queue_random(35);
        drain();

        // phase 4, both sides idling, random gains
        for (int g = 0; g < 7; g++)
            gains[g] = GAIN_W'($urandom_range(GAIN_MAX));
        write_all_gains(gains);
        tx_idle_pct  = 35;
        rx_stall_pct = 35;
        queue_random(35);
        drain();

        repeat (20) @(posedge clk);
        if (mismatches == 0 && expected_q.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
